// ===== hw/rtl/ncfc_pkg.sv =====
// Shared types and constants for the NIC credit flow control block.
`timescale 1ns / 1ps
`default_nettype none

package ncfc_pkg;

	localparam int WORD_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int OP_W      = 2;
	localparam int GRP_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_FC_RECEIVE = 2'd0;
	localparam logic [OP_W-1:0] OP_TX_REQUEST = 2'd1;
	localparam logic [OP_W-1:0] OP_DATA_RECV  = 2'd2;
	localparam logic [OP_W-1:0] OP_SET_THRESH = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 2'd2;

	localparam logic [WORD_W-1:0] QUEUE_HIGH_RST = 32'd65536;
	localparam logic [WORD_W-1:0] QUEUE_LOW_RST  = 32'd16384;
	localparam logic [WORD_W-1:0] CEILING_RST    = 32'd1048576;

	typedef struct packed {
		logic [WORD_W-1:0] queue_high;
		logic [WORD_W-1:0] queue_low;
		logic [WORD_W-1:0] ceiling;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [GRP_W-1:0]  grp;
		logic              ack;
		logic [SIZE_W-1:0] size;
		logic [WORD_W-1:0] limit_in;
		logic [WORD_W-1:0] ret_in;
		logic [WORD_W-1:0] qlen;
		logic              tap;
		logic [WORD_W-1:0] thr_in;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] used;
		logic [WORD_W-1:0] recycled;
		logic [WORD_W-1:0] limit;
		logic [WORD_W-1:0] drained;
		logic              tap;
	} grp_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] limit;
		logic [WORD_W-1:0] sent;
	} port_state_t;

	typedef struct packed {
		logic              granted;
		logic              tap_mark;
		logic              return_valid;
		logic [GRP_W-1:0]  return_group;
		logic [WORD_W-1:0] return_drained;
		logic              return_tap;
		logic [WORD_W-1:0] port_credit;
		logic [WORD_W-1:0] group_inflight;
		logic [WORD_W-1:0] group_threshold;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ncfc_step.sv =====
// Next-state and result logic for one beat of the credit flow control block.
`timescale 1ns / 1ps
`default_nettype none

module ncfc_step (
	input  ncfc_pkg::item_t       item,
	input  ncfc_pkg::cfg_t        cfg,
	input  ncfc_pkg::grp_state_t  grp_cur,
	input  ncfc_pkg::port_state_t port_cur,
	output ncfc_pkg::grp_state_t  grp_nxt,
	output ncfc_pkg::port_state_t port_nxt,
	output ncfc_pkg::result_t     res
);
	import ncfc_pkg::*;

	logic [WORD_W-1:0] size_w;
	logic [WORD_W-1:0] credit;
	logic [WORD_W-1:0] infl;
	logic [WORD_W-1:0] fc_infl;
	logic [WORD_W-1:0] cut_val;
	logic [WORD_W-1:0] grow_val;
	logic [WORD_W-1:0] headroom;
	logic [WORD_W-1:0] need;
	logic              ok;

	assign size_w   = WORD_W'(item.size);
	assign credit   = port_cur.limit - port_cur.sent;
	assign infl     = grp_cur.used - grp_cur.recycled;
	assign fc_infl  = grp_cur.used - item.ret_in;
	assign cut_val  = fc_infl + cfg.queue_low - item.qlen;
	assign grow_val = grp_cur.limit + cfg.queue_low - item.qlen;
	assign headroom = grp_cur.limit - infl;
	assign need     = size_w + infl;

	always_comb begin
		if (item.ack) begin
			ok = (credit >= size_w) && (headroom >= size_w);
		end else begin
			ok = (credit >= size_w) && (grp_cur.limit > need);
		end
	end

	always_comb begin
		grp_nxt  = grp_cur;
		port_nxt = port_cur;
		res      = '0;
		case (item.op)
			OP_FC_RECEIVE: begin
				port_nxt.limit   = item.limit_in;
				grp_nxt.recycled = item.ret_in;
				if (item.qlen > cfg.queue_high) begin
					grp_nxt.limit = (cut_val != '0 && !cut_val[WORD_W-1]) ? cut_val : '0;
					grp_nxt.tap   = 1'b1;
				end else if (item.qlen <= cfg.queue_low && grp_cur.limit != cfg.ceiling) begin
					grp_nxt.limit = (grow_val > cfg.ceiling) ? cfg.ceiling : grow_val;
					grp_nxt.tap   = 1'b1;
				end
			end
			OP_TX_REQUEST: begin
				if (ok) begin
					res.granted   = 1'b1;
					res.tap_mark  = grp_cur.tap;
					port_nxt.sent = port_cur.sent + size_w;
					grp_nxt.used  = grp_cur.used + size_w;
					grp_nxt.tap   = 1'b0;
				end
			end
			OP_DATA_RECV: begin
				grp_nxt.drained    = grp_cur.drained + size_w;
				res.return_valid   = 1'b1;
				res.return_group   = item.grp;
				res.return_drained = grp_cur.drained + size_w;
				res.return_tap     = item.tap;
			end
			OP_SET_THRESH: begin
				grp_nxt.limit = item.thr_in;
			end
			default: begin
				grp_nxt = grp_cur;
			end
		endcase
		res.port_credit     = port_nxt.limit - port_nxt.sent;
		res.group_inflight  = grp_nxt.used - grp_nxt.recycled;
		res.group_threshold = grp_nxt.limit;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/nic_credit_flow_control.sv =====
// Top level of the NIC credit flow control block: input stage, counters, result register.
// An accepted beat is held in the input stage, then its result is registered in res_q.
// Throughput: one beat per cycle unless out_stall holds back a pending result; the per-group
// counter read-modify-write is combinational between the input stage and the result register.
// Reset: arst_n clears all counters, thresholds and tap marks and loads the default
// queue marks and threshold ceiling; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module nic_credit_flow_control #(
	parameter int NUM_GROUPS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ncfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ncfc_pkg::WORD_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ncfc_pkg::OP_W-1:0]           operation,
	input  logic [ncfc_pkg::GRP_W-1:0]          group,
	input  logic                                is_ack,
	input  logic [ncfc_pkg::SIZE_W-1:0]         packet_bytes,
	input  logic [ncfc_pkg::WORD_W-1:0]         credit_limit_in,
	input  logic [ncfc_pkg::WORD_W-1:0]         credit_return_in,
	input  logic [ncfc_pkg::WORD_W-1:0]         remote_qlen,
	input  logic                                tap_in,
	input  logic [ncfc_pkg::WORD_W-1:0]         threshold_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                granted,
	output logic                                tap_mark,
	output logic                                return_valid,
	output logic [ncfc_pkg::GRP_W-1:0]          return_group,
	output logic [ncfc_pkg::WORD_W-1:0]         return_drained,
	output logic                                return_tap,
	output logic [ncfc_pkg::WORD_W-1:0]         port_credit,
	output logic [ncfc_pkg::WORD_W-1:0]         group_inflight,
	output logic [ncfc_pkg::WORD_W-1:0]         group_threshold
);
	import ncfc_pkg::*;

	localparam int GW = $clog2(NUM_GROUPS);

	cfg_t        cfg_q;
	item_t       item_in;
	item_t       item_s1;
	logic        valid_s1;
	logic [GW-1:0] idx_in;
	logic [GW-1:0] idx_s1;
	logic [GRP_W-1:0] grp_forced;
	logic        accept;
	logic        advance;
	grp_state_t  grp_q [NUM_GROUPS];
	port_state_t port_q;
	grp_state_t  grp_nxt;
	port_state_t port_nxt;
	result_t     res;
	result_t     res_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queue_high <= QUEUE_HIGH_RST;
			cfg_q.queue_low  <= QUEUE_LOW_RST;
			cfg_q.ceiling    <= CEILING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUEUE_HIGH: cfg_q.queue_high <= cfg_data;
				CFG_QUEUE_LOW:  cfg_q.queue_low  <= cfg_data;
				CFG_CEILING:    cfg_q.ceiling    <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// force acks of tx requests and data receives onto group 1, then fold the group into range
	assign grp_forced = (is_ack && (operation == OP_TX_REQUEST || operation == OP_DATA_RECV))
		? GRP_W'(1) : group;

	always_comb begin
		idx_in = '0;
		for (int i = 0; i < (1 << GRP_W); i++) begin
			if (grp_forced == GRP_W'(i)) begin
				idx_in = GW'(i % NUM_GROUPS);
			end
		end
	end

	always_comb begin
		item_in.op       = operation;
		item_in.grp      = GRP_W'(idx_in);
		item_in.ack      = is_ack;
		item_in.size     = packet_bytes;
		item_in.limit_in = credit_limit_in;
		item_in.ret_in   = credit_return_in;
		item_in.qlen     = remote_qlen;
		item_in.tap      = tap_in;
		item_in.thr_in   = threshold_value;
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			idx_s1  <= idx_in;
		end
	end

	ncfc_step u_step (
		.item     (item_s1),
		.cfg      (cfg_q),
		.grp_cur  (grp_q[idx_s1]),
		.port_cur (port_q),
		.grp_nxt  (grp_nxt),
		.port_nxt (port_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= '0;
			for (int i = 0; i < NUM_GROUPS; i++) begin
				grp_q[i] <= '0;
			end
		end else if (advance) begin
			port_q        <= port_nxt;
			grp_q[idx_s1] <= grp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted         = res_q.granted;
	assign tap_mark        = res_q.tap_mark;
	assign return_valid    = res_q.return_valid;
	assign return_group    = res_q.return_group;
	assign return_drained  = res_q.return_drained;
	assign return_tap      = res_q.return_tap;
	assign port_credit     = res_q.port_credit;
	assign group_inflight  = res_q.group_inflight;
	assign group_threshold = res_q.group_threshold;

endmodule

`default_nettype wire
